>>> src/mnhe_pkg.sv
// ----------------------------------------------------------------------------
// MIDI note hold engine package
// Shared constants, codes, controller/datapath interface types and helpers.
// ----------------------------------------------------------------------------
package mnhe_pkg;

   localparam int TRACKS          = 4;
   localparam int SLOTS_PER_TRACK = 8;
   localparam int NSLOTS          = TRACKS * SLOTS_PER_TRACK;

   // register layout always carries four tracks
   localparam int CFG_TRACKS = 4;

   localparam int TRK_W  = 2;
   localparam int SUB_W  = (SLOTS_PER_TRACK > 1) ? $clog2(SLOTS_PER_TRACK) : 1;
   localparam int IDX_W  = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
   localparam int KIND_W = 2;
   localparam int NOTE_W = 7;
   localparam int VEL_W  = 7;
   localparam int CHAN_W = 4;
   localparam int TS_W   = 32;
   localparam int MODE_W = 3;
   localparam int DUR_W  = 14;
   localparam int THR_W  = 7;

   localparam int ENTRY_W = NOTE_W + CHAN_W + TS_W;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 56;

   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = KIND_W + TRK_W;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = TRK_W;

   // input kinds
   localparam logic [KIND_W-1:0] KIND_NOTE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RELALL = 2'd2;

   // hold modes
   localparam logic [MODE_W-1:0] MODE_DISABLED = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LATCH    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TIMED    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_NEXT     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_MAX      = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODES      = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATIONS  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLDS = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MONO       = 4'd3;

   localparam logic [DUR_W-1:0] DUR_DEFAULT = 14'd2000;
   localparam logic [DUR_W-1:0] DUR_MIN     = 14'd100;
   localparam logic [DUR_W-1:0] DUR_MAX     = 14'd10000;
   localparam logic [THR_W-1:0] THR_MIN     = 7'd1;
   localparam logic [THR_W-1:0] THR_MAX     = 7'd127;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ECHO,
      ST_RD,
      ST_EV,
      ST_INSERT,
      ST_FLUSH
   } ctrl_state_type;

   // what a slot walk is for
   typedef enum logic [1:0] {
      WK_TICK,
      WK_LATCH,
      WK_CLEAR,
      WK_CLEAR_INS
   } walk_type;

   typedef struct packed {
      logic     load_req;
      logic     tick_inc;
      logic     walk_start;
      logic     walk_tick;
      logic     walk_step;
      logic     rd_issue;
      logic     emit_echo;
      logic     emit_slot;
      logic     insert;
      logic     flush;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              trk_ok;
      logic              disabled;
      logic              below;
      logic              latch;
      logic              rel_first;
      logic              can_emit;
      logic              live;
      logic              hit;
      logic              at_end;
   } dp_status_type;

   function automatic logic [IDX_W-1:0] slot_index(input logic [TRK_W-1:0] trk,
                                                   input logic [SUB_W-1:0] sub);
      logic [IDX_W+TRK_W+SUB_W-1:0] full;
      full = (IDX_W+TRK_W+SUB_W)'(trk) * (IDX_W+TRK_W+SUB_W)'(SLOTS_PER_TRACK)
           + (IDX_W+TRK_W+SUB_W)'(sub);
      return full[IDX_W-1:0];
   endfunction

endpackage

>>> src/midi_note_hold_engine_unit.sv
// ----------------------------------------------------------------------------
// MIDI note hold engine
// Per-track note sustainer: latch, timed, next-note and infinite hold modes.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : input transactions. tuser carries kind (note event, 1 ms tick,
//            release all of a track) and track; tdata carries note, velocity,
//            channel and time stamp. One transaction is taken at a time.
//   rsp_*  : note messages produced by a transaction, in order; tlast marks
//            the final message of a transaction. A transaction may produce
//            none (ignored note-off, empty track, tick releasing nothing).
//   csr_*  : register writes (modes, durations, thresholds, mono), accepted
//            every cycle; write only while the engine is idle.
// Timing
//   A note event passes dispatch and echo, then a table walk over the slots
//   of its track for each of: a latch search, then a mono or next-note
//   release, so at most two walks. A tick walks all 32 slots, with an
//   extra read step per held timed note. The walk over the single-port
//   slot table sets the time a transaction takes.
//   Results pass through a pending stage and an output register; a stalled
//   receiver holds the walk only when both are full. The next request is
//   taken once the last result of the previous one sits in the output
//   register.
// Reset
//   Synchronous, active high: no notes held, tick counter zero, all tracks
//   disabled, durations 2000 ms, thresholds 1, mono off.
// ----------------------------------------------------------------------------
module midi_note_hold_engine_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [6:0] note_number, [13:7] in_velocity, [17:14] midi_channel,
   // [49:18] time_stamp, [55:50] zero
   input  logic [mnhe_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] kind, [3:2] track
   input  logic [mnhe_pkg::REQ_USER_W-1:0]     req_tuser,
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [6:0] out_note, [13:7] out_velocity, [17:14] out_channel, [23:18] zero
   output logic [mnhe_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [1:0] out_track
   output logic [mnhe_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast,
   // register write port
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mnhe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mnhe_pkg::CSR_DATA_W-1:0]     csr_data
);
   import mnhe_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   walk_type      walk;

   logic [NOTE_W-1:0] rsp_note;
   logic [VEL_W-1:0]  rsp_velocity;
   logic [CHAN_W-1:0] rsp_channel;

   // register writes never stall
   assign csr_ready = 1'b1;

   mnhe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd),
      .walk       (walk)
   );

   mnhe_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_kind     (req_tuser[KIND_W-1:0]),
      .req_track    (req_tuser[KIND_W +: TRK_W]),
      .req_note     (req_tdata[NOTE_W-1:0]),
      .req_velocity (req_tdata[NOTE_W +: VEL_W]),
      .req_channel  (req_tdata[NOTE_W+VEL_W +: CHAN_W]),
      .req_time     (req_tdata[NOTE_W+VEL_W+CHAN_W +: TS_W]),
      .csr_wr       (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .walk         (walk),
      .status       (status),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_track    (rsp_tuser),
      .rsp_note     (rsp_note),
      .rsp_velocity (rsp_velocity),
      .rsp_channel  (rsp_channel),
      .rsp_tlast    (rsp_tlast)
   );

   // pack result fields, zero fill to a whole byte
   assign rsp_tdata = {(RSP_DATA_W-NOTE_W-VEL_W-CHAN_W)'(0),
                       rsp_channel, rsp_velocity, rsp_note};

endmodule

>>> src/mnhe_ctrl.sv
// ----------------------------------------------------------------------------
// MIDI note hold engine controller
// Sequences one transaction at a time: echo, slot walks, insert and flush.
// ----------------------------------------------------------------------------
module mnhe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  mnhe_pkg::dp_status_type status,
   output mnhe_pkg::ctrl_cmd_type  cmd,
   output mnhe_pkg::walk_type      walk
);
   import mnhe_pkg::*;

   ctrl_state_type state_ff, state_in;
   walk_type       walk_ff, walk_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         walk_ff  <= WK_TICK;
      end else begin
         state_ff <= state_in;
         walk_ff  <= walk_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   // walk purpose straight from the register
   assign walk = walk_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      walk_in  = walk_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (status.kind)
               KIND_NOTE: begin
                  if (status.trk_ok && (status.disabled || !status.below))
                     state_in = ST_ECHO;
                  else
                     state_in = ST_FLUSH;
               end
               KIND_TICK: begin
                  state_in = ST_RD;
                  walk_in  = WK_TICK;
               end
               KIND_RELALL: begin
                  if (status.trk_ok) begin
                     state_in = ST_RD;
                     walk_in  = WK_CLEAR;
                  end else begin
                     state_in = ST_FLUSH;
                  end
               end
               default: state_in = ST_FLUSH;
            endcase
         end
         ST_ECHO: begin
            if (status.can_emit) begin
               if (status.disabled) begin
                  state_in = ST_FLUSH;
               end else if (status.latch) begin
                  state_in = ST_RD;
                  walk_in  = WK_LATCH;
               end else if (status.rel_first) begin
                  state_in = ST_RD;
                  walk_in  = WK_CLEAR_INS;
               end else begin
                  state_in = ST_INSERT;
               end
            end
         end
         ST_RD, ST_EV: begin
            if (state_ff == ST_RD && status.live) begin
               state_in = ST_EV;
            end else if (state_ff == ST_EV && status.hit && !status.can_emit) begin
               state_in = ST_EV;
            end else if (state_ff == ST_EV && status.hit && walk_ff == WK_LATCH) begin
               state_in = ST_FLUSH;
            end else if (!status.at_end) begin
               state_in = ST_RD;
            end else begin
               // walk finished
               case (walk_ff)
                  WK_CLEAR_INS: state_in = ST_INSERT;
                  WK_LATCH: begin
                     if (status.rel_first) begin
                        state_in = ST_RD;
                        walk_in  = WK_CLEAR_INS;
                     end else begin
                        state_in = ST_INSERT;
                     end
                  end
                  default: state_in = ST_FLUSH;
               endcase
            end
         end
         ST_INSERT: state_in = ST_FLUSH;
         ST_FLUSH: begin
            if (status.can_emit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: cmd.load_req = req_tvalid;
         ST_DISPATCH: begin
            if (status.kind == KIND_TICK) begin
               cmd.tick_inc   = 1'b1;
               cmd.walk_start = 1'b1;
               cmd.walk_tick  = 1'b1;
            end else if (status.kind == KIND_RELALL && status.trk_ok) begin
               cmd.walk_start = 1'b1;
            end
         end
         ST_ECHO: begin
            cmd.emit_echo  = status.can_emit;
            cmd.walk_start = status.can_emit && !status.disabled
                           && (status.latch || status.rel_first);
         end
         ST_RD, ST_EV: begin
            if (state_ff == ST_RD && status.live) begin
               cmd.rd_issue = 1'b1;
            end else if (state_ff == ST_EV && status.hit && !status.can_emit) begin
               cmd.rd_issue = 1'b0;
            end else begin
               cmd.emit_slot = (state_ff == ST_EV) && status.hit;
               if (!(state_ff == ST_EV && status.hit && walk_ff == WK_LATCH)) begin
                  if (!status.at_end)
                     cmd.walk_step = 1'b1;
                  else if (walk_ff == WK_LATCH && status.rel_first)
                     cmd.walk_start = 1'b1;
               end
            end
         end
         ST_INSERT: cmd.insert = 1'b1;
         ST_FLUSH:  cmd.flush  = status.can_emit;
         default: cmd = '0;
      endcase
   end

endmodule

>>> src/mnhe_dp.sv
// ----------------------------------------------------------------------------
// MIDI note hold engine datapath
// Config registers, slot table, tick counter, walk counters, result staging.
// ----------------------------------------------------------------------------
module mnhe_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [mnhe_pkg::KIND_W-1:0]       req_kind,
   input  logic [mnhe_pkg::TRK_W-1:0]        req_track,
   input  logic [mnhe_pkg::NOTE_W-1:0]       req_note,
   input  logic [mnhe_pkg::VEL_W-1:0]        req_velocity,
   input  logic [mnhe_pkg::CHAN_W-1:0]       req_channel,
   input  logic [mnhe_pkg::TS_W-1:0]         req_time,
   input  logic                              csr_wr,
   input  logic [mnhe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mnhe_pkg::CSR_DATA_W-1:0]   csr_data,
   input  mnhe_pkg::ctrl_cmd_type            cmd,
   input  mnhe_pkg::walk_type                walk,
   output mnhe_pkg::dp_status_type           status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mnhe_pkg::TRK_W-1:0]        rsp_track,
   output logic [mnhe_pkg::NOTE_W-1:0]       rsp_note,
   output logic [mnhe_pkg::VEL_W-1:0]        rsp_velocity,
   output logic [mnhe_pkg::CHAN_W-1:0]       rsp_channel,
   output logic                              rsp_tlast
);
   import mnhe_pkg::*;

   // configuration
   logic [MODE_W-1:0] mode_ff [CFG_TRACKS];
   logic [MODE_W-1:0] mode_in [CFG_TRACKS];
   logic [DUR_W-1:0]  dur_ff  [CFG_TRACKS];
   logic [DUR_W-1:0]  dur_in  [CFG_TRACKS];
   logic [THR_W-1:0]  thr_ff  [CFG_TRACKS];
   logic [THR_W-1:0]  thr_in  [CFG_TRACKS];
   logic [CFG_TRACKS-1:0] mono_ff, mono_in;

   always_comb begin
      logic [MODE_W-1:0] m;
      logic [DUR_W-1:0]  d;
      logic [THR_W-1:0]  th;
      for (int t = 0; t < CFG_TRACKS; t++) begin
         m  = csr_data[MODE_W*t +: MODE_W];
         d  = csr_data[DUR_W*t +: DUR_W];
         th = csr_data[THR_W*t +: THR_W];
         mode_in[t] = mode_ff[t];
         dur_in[t]  = dur_ff[t];
         thr_in[t]  = thr_ff[t];
         if (csr_wr && csr_index == CSR_MODES && m <= MODE_MAX)
            mode_in[t] = m;
         if (csr_wr && csr_index == CSR_DURATIONS)
            dur_in[t] = (d < DUR_MIN) ? DUR_MIN : ((d > DUR_MAX) ? DUR_MAX : d);
         if (csr_wr && csr_index == CSR_THRESHOLDS)
            thr_in[t] = (th < THR_MIN) ? THR_MIN : th;
      end
      mono_in = (csr_wr && csr_index == CSR_MONO) ? csr_data[CFG_TRACKS-1:0] : mono_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < CFG_TRACKS; t++) begin
            mode_ff[t] <= MODE_DISABLED;
            dur_ff[t]  <= DUR_DEFAULT;
            thr_ff[t]  <= THR_MIN;
         end
         mono_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         dur_ff  <= dur_in;
         thr_ff  <= thr_in;
         mono_ff <= mono_in;
      end
   end

   // captured request
   logic [KIND_W-1:0] kind_ff;
   logic [TRK_W-1:0]  trk_ff;
   logic [NOTE_W-1:0] note_ff;
   logic [VEL_W-1:0]  vel_ff;
   logic [CHAN_W-1:0] chan_ff;
   logic [TS_W-1:0]   ts_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff <= req_kind;
         trk_ff  <= req_track;
         note_ff <= req_note;
         vel_ff  <= req_velocity;
         chan_ff <= req_channel;
         ts_ff   <= req_time;
      end
   end

   // tick counter
   logic [TS_W-1:0] tick_ff;

   always_ff @(posedge clock) begin
      if (reset)             tick_ff <= '0;
      else if (cmd.tick_inc) tick_ff <= tick_ff + TS_W'(1);
   end

   // walk counters
   logic [TRK_W-1:0] wtrk_ff;
   logic [SUB_W-1:0] sub_ff;
   logic [IDX_W-1:0] idx;
   logic             sub_last;

   assign idx      = slot_index(wtrk_ff, sub_ff);
   assign sub_last = (sub_ff == SUB_W'(SLOTS_PER_TRACK - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         wtrk_ff <= '0;
         sub_ff  <= '0;
      end else if (cmd.walk_start) begin
         wtrk_ff <= cmd.walk_tick ? '0 : trk_ff;
         sub_ff  <= '0;
      end else if (cmd.walk_step) begin
         if (sub_last) begin
            sub_ff  <= '0;
            wtrk_ff <= wtrk_ff + TRK_W'(1);
         end else begin
            sub_ff <= sub_ff + SUB_W'(1);
         end
      end
   end

   // free slot search for insert
   logic             free_found;
   logic [IDX_W-1:0] free_idx;
   logic [NSLOTS-1:0] valid_ff;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int s = 0; s < SLOTS_PER_TRACK; s++) begin
         if (!free_found && !valid_ff[slot_index(trk_ff, SUB_W'(s))]) begin
            free_found = 1'b1;
            free_idx   = slot_index(trk_ff, SUB_W'(s));
         end
      end
   end

   // slot valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (cmd.emit_slot)
            valid_ff[idx] <= 1'b0;
         if (cmd.insert && free_found)
            valid_ff[free_idx] <= 1'b1;
      end
   end

   // slot table: note, channel, start time
   logic [ENTRY_W-1:0] entry_mem [NSLOTS];
   logic [ENTRY_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.insert && free_found)
         entry_mem[free_idx] <= {ts_ff, chan_ff, note_ff};
      if (cmd.rd_issue)
         rd_ff <= entry_mem[idx];
   end

   logic [NOTE_W-1:0] rd_note;
   logic [CHAN_W-1:0] rd_chan;
   logic [TS_W-1:0]   rd_start;
   logic [TS_W-1:0]   elapsed;

   assign rd_note  = rd_ff[NOTE_W-1:0];
   assign rd_chan  = rd_ff[NOTE_W +: CHAN_W];
   assign rd_start = rd_ff[NOTE_W+CHAN_W +: TS_W];
   assign elapsed  = tick_ff - rd_start;

   // result staging: one pending item so the final one can carry tlast
   logic              pend_valid_ff;
   logic [TRK_W-1:0]  p_trk_ff;
   logic [NOTE_W-1:0] p_note_ff;
   logic [VEL_W-1:0]  p_vel_ff;
   logic [CHAN_W-1:0] p_chan_ff;
   logic              out_valid_ff;
   logic              out_free;
   logic              emit;
   logic              load_out;

   assign out_free = !out_valid_ff || rsp_tready;
   assign emit     = cmd.emit_echo || cmd.emit_slot;
   assign load_out = pend_valid_ff && (emit || cmd.flush);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (emit)
            pend_valid_ff <= 1'b1;
         else if (cmd.flush)
            pend_valid_ff <= 1'b0;
         if (load_out)
            out_valid_ff <= 1'b1;
         else if (rsp_tready)
            out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_echo) begin
         p_trk_ff  <= trk_ff;
         p_note_ff <= note_ff;
         p_vel_ff  <= vel_ff;
         p_chan_ff <= chan_ff;
      end else if (cmd.emit_slot) begin
         p_trk_ff  <= wtrk_ff;
         p_note_ff <= rd_note;
         p_vel_ff  <= '0;
         p_chan_ff <= rd_chan;
      end
      if (load_out) begin
         rsp_track    <= p_trk_ff;
         rsp_note     <= p_note_ff;
         rsp_velocity <= p_vel_ff;
         rsp_channel  <= p_chan_ff;
         rsp_tlast    <= cmd.flush;
      end
   end

   assign rsp_tvalid = out_valid_ff;

   // status
   always_comb begin
      status           = '0;
      status.kind      = kind_ff;
      status.trk_ok    = ({1'b0, trk_ff} < (TRK_W+1)'(TRACKS));
      status.disabled  = (mode_ff[trk_ff] == MODE_DISABLED);
      status.below     = (vel_ff < thr_ff[trk_ff]);
      status.latch     = (mode_ff[trk_ff] == MODE_LATCH);
      status.rel_first = mono_ff[trk_ff] || (mode_ff[trk_ff] == MODE_NEXT);
      status.can_emit  = !pend_valid_ff || out_free;
      status.live      = valid_ff[idx]
                       && (walk != WK_TICK || mode_ff[wtrk_ff] == MODE_TIMED);
      case (walk)
         WK_TICK:  status.hit = (elapsed >= TS_W'(dur_ff[wtrk_ff]));
         WK_LATCH: status.hit = (rd_note == note_ff) && (rd_chan == chan_ff);
         default:  status.hit = 1'b1;
      endcase
      status.at_end = sub_last
                    && (walk != WK_TICK || wtrk_ff == TRK_W'(TRACKS - 1));
   end

endmodule
